// ===== rtl/core/crp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crp_pkg: shared definitions for the cell reference parser
// Accumulator limits, character codes and result status codes.
// ----------------------------------------------------------------------------
package crp_pkg;

    // Column number may reach 2^COL_BITS, row number 2^ROW_BITS
    localparam int COL_BITS = 16;
    localparam int ROW_BITS = 20;

    // Result field widths
    localparam int CHAR_W   = 8;
    localparam int COL_W    = 16;
    localparam int ROW_W    = 20;
    localparam int STATUS_W = 2;

    // Output tdata: col_index then row_index, padded to whole bytes
    localparam int M_TDATA_W = ((COL_W + ROW_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - COL_W - ROW_W;

    // Accumulators hold the limit plus one; products have headroom for one step
    localparam int COL_ACC_W  = COL_BITS + 1;
    localparam int ROW_ACC_W  = ROW_BITS + 1;
    localparam int COL_PROD_W = COL_ACC_W + 5;
    localparam int ROW_PROD_W = ROW_ACC_W + 4;

    // Letter value 1..26 and digit value 0..9
    localparam int LV_W = 5;
    localparam int DV_W = 4;

    localparam logic [CHAR_W-1:0] ALPHA_COUNT = 8'd26;
    localparam logic [CHAR_W-1:0] DEC_COUNT   = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

endpackage

// ===== rtl/core/cell_reference_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_reference_parser: spreadsheet cell reference parser
// Reads a reference one character per item, builds a bijective base-26
// column and a decimal row, and returns status, column and row on the last
// character of the reference.
// ----------------------------------------------------------------------------
// A result is registered and is presented in the cycle after its last character is taken.
// Throughput: one character per cycle while s_tready is high; the column and row
// multiply-adds by the constants 26 and 10 plus the phase update are combinational.
// A waiting result does not stall input unless the result register is full
// and the downstream side holds tready low.
// Reset (aresetn low, synchronous): parser returns to the leading-space phase,
// accumulators clear and the result register empties.
module cell_reference_parser (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Character stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [crp_pkg::CHAR_W-1:0]      s_tdata,   // [7:0] char_code
    input  logic                            s_tlast,   // last
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [crp_pkg::M_TDATA_W-1:0]   m_tdata,   // [15:0] col_index, [35:16] row_index
    output logic [crp_pkg::STATUS_W-1:0]    m_tuser    // [1:0] status
);

    typedef enum logic [2:0] {
        PH_LEAD    = 3'd0,
        PH_LETTERS = 3'd1,
        PH_DIGITS  = 3'd2,
        PH_TRAIL   = 3'd3,
        PH_ERROR   = 3'd4
    } phase_t;

    localparam logic [crp_pkg::COL_PROD_W-1:0] COL_LIMIT =
        crp_pkg::COL_PROD_W'(1) << crp_pkg::COL_BITS;
    localparam logic [crp_pkg::ROW_PROD_W-1:0] ROW_LIMIT =
        crp_pkg::ROW_PROD_W'(1) << crp_pkg::ROW_BITS;

    phase_t                            phase_reg, phase_next;
    logic [crp_pkg::COL_ACC_W-1:0]     col_acc_reg, col_acc_next;
    logic [crp_pkg::ROW_ACC_W-1:0]     row_acc_reg, row_acc_next;
    logic                              ovf_reg, ovf_next;

    logic                              m_valid_reg;
    crp_pkg::status_t                  status_reg, status_next;
    logic [crp_pkg::COL_W-1:0]         col_reg, col_next;
    logic [crp_pkg::ROW_W-1:0]         row_reg, row_next;

    logic                              in_acc;
    logic [crp_pkg::CHAR_W-1:0]        up_diff, lo_diff, dg_diff;
    logic                              is_upper, is_lower, is_letter, is_digit, is_space;
    logic [crp_pkg::LV_W-1:0]          letter_val;
    logic [crp_pkg::DV_W-1:0]          digit_val;

    logic [crp_pkg::COL_ACC_W-1:0]     col_base;
    logic [crp_pkg::ROW_ACC_W-1:0]     row_base;
    logic [crp_pkg::COL_PROD_W-1:0]    col_mac;
    logic [crp_pkg::ROW_PROD_W-1:0]    row_mac;
    logic                              col_big, row_big;
    logic [crp_pkg::COL_ACC_W-1:0]     col_sat;
    logic [crp_pkg::ROW_ACC_W-1:0]     row_sat;
    logic [crp_pkg::COL_BITS-1:0]      col_zb;
    logic [crp_pkg::ROW_BITS-1:0]      row_zb;

    // Take a character whenever the result register is free or being drained
    assign s_tready = !m_valid_reg || m_tready;
    assign in_acc   = s_tvalid && s_tready;

    // Classify the character
    assign up_diff   = s_tdata - crp_pkg::CHAR_UPPER_A;
    assign lo_diff   = s_tdata - crp_pkg::CHAR_LOWER_A;
    assign dg_diff   = s_tdata - crp_pkg::CHAR_ZERO;
    assign is_upper  = up_diff < crp_pkg::ALPHA_COUNT;
    assign is_lower  = lo_diff < crp_pkg::ALPHA_COUNT;
    assign is_letter = is_upper || is_lower;
    assign is_digit  = dg_diff < crp_pkg::DEC_COUNT;
    assign is_space  = s_tdata == crp_pkg::CHAR_SPACE;
    assign letter_val = is_upper ? crp_pkg::LV_W'(up_diff + 8'd1)
                                 : crp_pkg::LV_W'(lo_diff + 8'd1);
    assign digit_val  = crp_pkg::DV_W'(dg_diff);

    // Multiply-add with saturation at limit plus one
    assign col_base = (phase_reg == PH_LETTERS) ? col_acc_reg : '0;
    assign row_base = (phase_reg == PH_DIGITS)  ? row_acc_reg : '0;
    assign col_mac  = crp_pkg::COL_PROD_W'(col_base) * crp_pkg::COL_PROD_W'(crp_pkg::ALPHA_COUNT)
                    + crp_pkg::COL_PROD_W'(letter_val);
    assign row_mac  = crp_pkg::ROW_PROD_W'(row_base) * crp_pkg::ROW_PROD_W'(crp_pkg::DEC_COUNT)
                    + crp_pkg::ROW_PROD_W'(digit_val);
    assign col_big  = col_mac > COL_LIMIT;
    assign row_big  = row_mac > ROW_LIMIT;
    assign col_sat  = col_big ? crp_pkg::COL_ACC_W'(COL_LIMIT + 1'b1)
                              : crp_pkg::COL_ACC_W'(col_mac);
    assign row_sat  = row_big ? crp_pkg::ROW_ACC_W'(ROW_LIMIT + 1'b1)
                              : crp_pkg::ROW_ACC_W'(row_mac);

    // Phase and accumulator update for one character
    always_comb begin
        phase_next   = phase_reg;
        col_acc_next = col_acc_reg;
        row_acc_next = row_acc_reg;
        ovf_next     = ovf_reg;
        unique case (phase_reg)
            PH_LEAD: begin
                if (is_space) begin
                    phase_next = PH_LEAD;
                end else if (is_letter) begin
                    col_acc_next = col_sat;
                    ovf_next     = ovf_reg || col_big;
                    phase_next   = PH_LETTERS;
                end else begin
                    phase_next = PH_ERROR;
                end
            end
            PH_LETTERS: begin
                if (is_letter) begin
                    col_acc_next = col_sat;
                    ovf_next     = ovf_reg || col_big;
                end else if (is_digit && (digit_val != '0)) begin
                    row_acc_next = row_sat;
                    ovf_next     = ovf_reg || row_big;
                    phase_next   = PH_DIGITS;
                end else begin
                    phase_next = PH_ERROR;
                end
            end
            PH_DIGITS: begin
                if (is_digit) begin
                    row_acc_next = row_sat;
                    ovf_next     = ovf_reg || row_big;
                end else if (is_space) begin
                    phase_next = PH_TRAIL;
                end else begin
                    phase_next = PH_ERROR;
                end
            end
            PH_TRAIL: begin
                if (!is_space) begin
                    phase_next = PH_ERROR;
                end
            end
            default: begin
                phase_next = PH_ERROR;
            end
        endcase
    end

    // Build the result from the updated state
    assign col_zb = crp_pkg::COL_BITS'(col_acc_next - 1'b1);
    assign row_zb = crp_pkg::ROW_BITS'(row_acc_next - 1'b1);

    always_comb begin
        status_next = crp_pkg::ST_OK;
        col_next    = '0;
        row_next    = '0;
        priority if (phase_next != PH_DIGITS && phase_next != PH_TRAIL) begin
            status_next = crp_pkg::ST_MALFORMED;
        end else if (ovf_next) begin
            status_next = crp_pkg::ST_OVERFLOW;
        end else begin
            col_next = crp_pkg::COL_W'(col_zb);
            row_next = crp_pkg::ROW_W'(row_zb);
        end
    end

    // Parser state: advance on each item, restart after the last one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_LEAD;
            col_acc_reg <= '0;
            row_acc_reg <= '0;
            ovf_reg     <= 1'b0;
        end else if (in_acc) begin
            if (s_tlast) begin
                phase_reg   <= PH_LEAD;
                col_acc_reg <= '0;
                row_acc_reg <= '0;
                ovf_reg     <= 1'b0;
            end else begin
                phase_reg   <= phase_next;
                col_acc_reg <= col_acc_next;
                row_acc_reg <= row_acc_next;
                ovf_reg     <= ovf_next;
            end
        end
    end

    // Result register: load on the last item, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_acc && s_tlast) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc && s_tlast) begin
            status_reg <= status_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {{crp_pkg::M_PAD_W{1'b0}}, row_reg, col_reg};

    // A result appears only after a last character was taken
    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("result without a preceding last character");

    // A taken last character always leaves a result pending
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
        else $error("last character produced no result");

    // Failed references carry zero column and row
    a_error_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != crp_pkg::ST_OK) |-> (m_tdata == '0))
        else $error("nonzero fields on a failed reference");

    // An empty result register never blocks input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

endmodule

// ===== dv/crp_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crp_result_checker: result predictor and scoreboard for the cell parser
// Watches the character and result streams and mirrors the parser state.
// Each accepted last character queues the predicted status, column and row.
// Each accepted result is compared field by field with the oldest entry in
// that queue, and every mismatch is counted.
// ----------------------------------------------------------------------------
module crp_result_checker
    import crp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [CHAR_W-1:0]    s_tdata,     // [7:0] char_code
    input  logic                 s_tlast,     // last
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,     // [15:0] col_index, [35:16] row_index
    input  logic [STATUS_W-1:0]  m_tuser,     // [1:0] status
    output int                   outstanding,
    output int                   mismatches
);

    localparam longint unsigned COL_LIMIT = 64'd1 << COL_BITS;
    localparam longint unsigned ROW_LIMIT = 64'd1 << ROW_BITS;

    typedef enum logic [2:0] {
        SCAN_LEAD,
        SCAN_ALPHA,
        SCAN_DIGIT,
        SCAN_TRAIL,
        SCAN_BAD
    } scan_phase_t;

    typedef struct {
        status_t              status;
        logic [COL_W-1:0]     col;
        logic [ROW_W-1:0]     row;
    } cell_result_t;

    cell_result_t         results_due[$];
    scan_phase_t          scan_phase;
    logic [COL_ACC_W-1:0] col_num;
    logic [ROW_ACC_W-1:0] row_num;
    logic                 num_overflow;
    int                   fail_total;

    // Letter rank 1..26 in either case, 0 for any other byte
    function automatic longint unsigned letter_rank(logic [CHAR_W-1:0] c);
        if (c >= CHAR_UPPER_A && c < CHAR_UPPER_A + ALPHA_COUNT)
            return c - CHAR_UPPER_A + 1;
        if (c >= CHAR_LOWER_A && c < CHAR_LOWER_A + ALPHA_COUNT)
            return c - CHAR_LOWER_A + 1;
        return 0;
    endfunction

    // Multiply-add one place; saturate at the limit plus one
    function automatic longint unsigned grow(longint unsigned acc, longint unsigned base,
                                             longint unsigned dig, longint unsigned lim);
        longint unsigned nxt;
        nxt = acc * base + dig;
        return (nxt > lim) ? lim + 1 : nxt;
    endfunction

    task automatic clear_scan();
        scan_phase   = SCAN_LEAD;
        col_num      = '0;
        row_num      = '0;
        num_overflow = 1'b0;
    endtask

    // Advance the mirrored parser by one character; queue a result on the last one
    task automatic take_char(logic [CHAR_W-1:0] c, logic is_end);
        longint unsigned      rank;
        logic                 is_sp;
        logic                 is_dig;
        longint unsigned      dval;
        cell_result_t         res;
        logic [COL_ACC_W-1:0] col_m1;
        logic [ROW_ACC_W-1:0] row_m1;

        rank   = letter_rank(c);
        is_sp  = (c == CHAR_SPACE);
        is_dig = (c >= CHAR_ZERO) && (c < CHAR_ZERO + DEC_COUNT);
        dval   = c - CHAR_ZERO;

        case (scan_phase)
            SCAN_LEAD: begin
                if (is_sp) begin
                end else if (rank != 0) begin
                    col_num    = COL_ACC_W'(grow(0, ALPHA_COUNT, rank, COL_LIMIT));
                    scan_phase = SCAN_ALPHA;
                end else begin
                    scan_phase = SCAN_BAD;
                end
            end
            SCAN_ALPHA: begin
                if (rank != 0) begin
                    col_num = COL_ACC_W'(grow(col_num, ALPHA_COUNT, rank, COL_LIMIT));
                end else if (is_dig && c != CHAR_ZERO) begin
                    row_num    = ROW_ACC_W'(grow(0, DEC_COUNT, dval, ROW_LIMIT));
                    scan_phase = SCAN_DIGIT;
                end else begin
                    scan_phase = SCAN_BAD;
                end
            end
            SCAN_DIGIT: begin
                if (is_dig)
                    row_num = ROW_ACC_W'(grow(row_num, DEC_COUNT, dval, ROW_LIMIT));
                else if (is_sp)
                    scan_phase = SCAN_TRAIL;
                else
                    scan_phase = SCAN_BAD;
            end
            SCAN_TRAIL: begin
                if (!is_sp)
                    scan_phase = SCAN_BAD;
            end
            default: scan_phase = SCAN_BAD;
        endcase

        // A saturated accumulator marks the reference as overflowed
        if (col_num > COL_LIMIT || row_num > ROW_LIMIT)
            num_overflow = 1'b1;

        if (is_end) begin
            col_m1     = col_num - 1'b1;
            row_m1     = row_num - 1'b1;
            res.status = ST_OK;
            res.col    = '0;
            res.row    = '0;
            if (scan_phase != SCAN_DIGIT && scan_phase != SCAN_TRAIL) begin
                res.status = ST_MALFORMED;
            end else if (num_overflow) begin
                res.status = ST_OVERFLOW;
            end else begin
                res.col = col_m1[COL_W-1:0];
                res.row = row_m1[ROW_W-1:0];
            end
            results_due.push_back(res);
            clear_scan();
        end
    endtask

    // Predict on accepted characters, then compare accepted results
    always @(posedge aclk) begin
        cell_result_t got;
        cell_result_t want;

        if (!aresetn) begin
            clear_scan();
            results_due.delete();
        end else begin
            if (s_tvalid && s_tready)
                take_char(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                got.status = status_t'(m_tuser);
                got.col    = m_tdata[COL_W-1:0];
                got.row    = m_tdata[COL_W +: ROW_W];
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result: status %0d col %0d row %0d",
                             $time, got.status, got.col, got.row);
                    fail_total++;
                end else begin
                    want = results_due.pop_front();
                    if (got.status != want.status) begin
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.status, got.status);
                        fail_total++;
                    end
                    if (got.col != want.col) begin
                        $display("%0t: col_index mismatch: expected %0d, got %0d",
                                 $time, want.col, got.col);
                        fail_total++;
                    end
                    if (got.row != want.row) begin
                        $display("%0t: row_index mismatch: expected %0d, got %0d",
                                 $time, want.row, got.row);
                        fail_total++;
                    end
                end
            end
        end
        outstanding <= results_due.size();
        mismatches  <= fail_total;
    end

endmodule

// ===== dv/cell_reference_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_reference_parser_tb: stimulus and verdict for the cell reference parser
// Feeds directed references (extremes, overflow, malformed forms, odd bytes),
// then well-formed random references mixed with broken ones, under random
// gaps on the character side and random stalls on the result side.
// A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module cell_reference_parser_tb;
    import crp_pkg::*;

    localparam int ITEM_TARGET = 850;
    localparam int CYCLE_LIMIT = 400000;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [CHAR_W-1:0]    s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    int                   outstanding;
    int                   mismatches;
    int                   cycle_count = 0;
    int                   items_sent  = 0;
    int                   refs_sent   = 0;
    int                   hold_left   = 0;
    bit                   steady      = 1'b0;
    logic [CHAR_W-1:0]    cell_text[$];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    cell_reference_parser i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    crp_result_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    // Mostly no gap, often a short one, rarely a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Stall the result side in random bursts, never during steady stretches
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left = 0;
        end else if (steady) begin
            m_tready  <= 1'b1;
            hold_left = 0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            hold_left = gap_len();
            m_tready  <= (hold_left == 0);
            if (hold_left > 0)
                hold_left = hold_left - 1;
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[cell_reference_parser] ERROR");
            $finish;
        end
    end

    // Offer one character, after an optional gap, and hold it until taken
    task automatic put_char(logic [CHAR_W-1:0] c, logic is_end);
        int gap;
        gap = steady ? 0 : gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= is_end;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_cells();
        for (int i = 0; i < cell_text.size(); i++)
            put_char(cell_text[i], i == cell_text.size() - 1);
        refs_sent++;
    endtask

    task automatic send_text(string txt);
        cell_text.delete();
        for (int i = 0; i < txt.len(); i++)
            cell_text.push_back(txt[i]);
        send_cells();
    endtask

    // Hold off the sender until every queued result has been taken
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [CHAR_W-1:0] pick_letter();
        logic [CHAR_W-1:0] base;
        base = $urandom_range(0, 1) ? CHAR_UPPER_A : CHAR_LOWER_A;
        return CHAR_W'(base + $urandom_range(0, ALPHA_COUNT - 1));
    endfunction

    function automatic logic [CHAR_W-1:0] pick_digit(bit nonzero);
        return CHAR_W'(CHAR_ZERO + $urandom_range(nonzero ? 1 : 0, DEC_COUNT - 1));
    endfunction

    // Any byte, biased toward the characters the parser cares about
    function automatic logic [CHAR_W-1:0] pick_mixed();
        case ($urandom_range(0, 3))
            0:       return pick_letter();
            1:       return pick_digit(1'b0);
            2:       return CHAR_SPACE;
            default: return CHAR_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Build spaces, letters, digits, spaces; a forced zero leads the row when asked
    task automatic build_ref(int n_alpha, int n_digit, bit zero_first);
        int n_lead;
        int n_trail;
        n_lead  = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
        n_trail = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
        cell_text.delete();
        repeat (n_lead) cell_text.push_back(CHAR_SPACE);
        repeat (n_alpha) cell_text.push_back(pick_letter());
        for (int i = 0; i < n_digit; i++)
            cell_text.push_back((i == 0 && zero_first) ? CHAR_ZERO : pick_digit(i == 0));
        repeat (n_trail) cell_text.push_back(CHAR_SPACE);
        if (cell_text.size() == 0)
            cell_text.push_back(CHAR_SPACE);
    endtask

    // Mostly well-formed references, the rest broken in assorted ways
    task automatic make_random_ref();
        int n_alpha;
        int n_digit;
        int len;
        n_alpha = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(4, 6);
        n_digit = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 8);
        if ($urandom_range(0, 99) < 70) begin
            build_ref(n_alpha, n_digit, 1'b0);
        end else begin
            case ($urandom_range(0, 6))
                0: begin
                    build_ref(n_alpha, n_digit, 1'b0);
                    cell_text[$urandom_range(0, cell_text.size() - 1)] =
                        CHAR_W'($urandom_range(0, 255));
                end
                1: begin
                    build_ref(n_alpha, n_digit, 1'b0);
                    cell_text.insert($urandom_range(1, cell_text.size()), CHAR_SPACE);
                end
                2: build_ref(n_alpha, n_digit, 1'b1);
                3: build_ref(n_alpha, 0, 1'b0);
                4: build_ref(0, n_digit, 1'b0);
                5: begin
                    len = $urandom_range(1, 6);
                    cell_text.delete();
                    repeat (len) cell_text.push_back(pick_mixed());
                end
                default: begin
                    build_ref(n_alpha, n_digit, 1'b0);
                    cell_text.push_back(pick_letter());
                end
            endcase
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Plain, mixed case, padded and extreme references
        send_text("A1");
        send_text("z10");
        send_text("  ab12  ");
        send_text("CRXP1048576");
        // Overflow on column, on row, on both, and overflow under a malformed tail
        send_text("CRXQ1");
        send_text("a1048577");
        send_text("ZZZZZ99999999");
        send_text("ZZZZZ1x");
        // Row zero, leading zero, missing parts, inner spaces, stray bytes
        send_text("A0");
        send_text("B01");
        send_text("1A");
        send_text("AB");
        send_text("   ");
        send_text("A 1");
        send_text("A1 B");
        send_text("A1-");
        send_text("@1");
        send_text("{1");
        send_text("`9");
        send_text("Q:");
        cell_text = '{8'h00};
        send_cells();
        cell_text = '{8'hFF, CHAR_UPPER_A, CHAR_ZERO + 1};
        send_cells();
        cell_text = '{CHAR_UPPER_A, 8'hB1};
        send_cells();
        wait_drained();

        // Random references, with a drain pause partway through
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 19) == 0)
                steady = !steady;
            if (refs_sent == 100)
                wait_drained();
            make_random_ref();
            send_cells();
        end
        s_tvalid <= 1'b0;
        steady = 1'b0;

        // Let the last results come out, then settle
        repeat (2) @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (mismatches == 0)
            $display("[cell_reference_parser] OK");
        else
            $display("[cell_reference_parser] ERROR");
        $finish;
    end

endmodule

// ===== cell_reference_parser.f =====
rtl/core/crp_pkg.sv
rtl/core/cell_reference_parser.sv
dv/crp_result_checker.sv
dv/cell_reference_parser_tb.sv
